// ===== rtl/mbvf_pkg.sv =====
// Shared types and constants for the mask boundary voxel finder.
// No dependencies; imported by every module of the block except mbvf_line.
package mbvf_pkg;

	localparam int DEF_MAX_X = 128;
	localparam int DEF_MAX_Y = 128;
	localparam int DEF_MAX_Z = 1024;

	localparam int NODE_W = 24;
	localparam int CFG_W  = 11;
	localparam int SX_W   = 8;
	localparam int SY_W   = 8;
	localparam int SZ_W   = 11;
	localparam int MODE_W = 2;

	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	typedef enum logic [1:0] {
		CFG_SIZE_X = 2'd0,
		CFG_SIZE_Y = 2'd1,
		CFG_SIZE_Z = 2'd2,
		CFG_NMODE  = 2'd3
	} cfg_reg_t;

	localparam logic [MODE_W-1:0] MODE_FACE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;

	localparam logic OP_VOXEL = 1'b0;
	localparam logic OP_PAD   = 1'b1;

	// one window advance, classified by the front end
	typedef struct packed {
		logic bit_in;
		logic emit;
		logic last;
		logic xlo;
		logic xhi;
		logic ylo;
		logic yhi;
		logic zlo;
		logic zhi;
	} entry_t;

endpackage

// ===== rtl/mask_boundary_voxel_finder_unit.sv =====
// Mask boundary voxel finder, top level.
// A result is registered at the output when the back end pops the transaction that completes
// its window (plane + row + 1 voxels after its own voxel); pad transactions flush the tail.
// Throughput: one transaction per cycle while the output is not stalled, set by the single-port
// plane and row delay lines. Reset: asynchronous; sizes 128x128x1, face mode, empty queue; ready
// low after reset or a register write while derived sizes settle.
module mask_boundary_voxel_finder_unit #(
	parameter int MAX_X = mbvf_pkg::DEF_MAX_X,
	parameter int MAX_Y = mbvf_pkg::DEF_MAX_Y,
	parameter int MAX_Z = mbvf_pkg::DEF_MAX_Z
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [mbvf_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic signed [7:0]             mask_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          in_mask,
	output logic                          is_boundary,
	output logic [mbvf_pkg::NODE_W-1:0]   node_number,
	output logic                          last
);
	import mbvf_pkg::*;

	localparam int XW  = $clog2(MAX_X + 1);
	localparam int YW  = $clog2(MAX_Y + 1);
	localparam int ZW  = $clog2(MAX_Z + 1);
	localparam int PLW = $clog2(MAX_X * MAX_Y + 1);
	localparam longint QMAX = longint'(MAX_X) * MAX_Y * MAX_Z + longint'(MAX_X) * MAX_Y + MAX_X;
	localparam int QW  = $clog2(QMAX + 1);
	localparam int RPW = $clog2(MAX_X);
	localparam int PPW = $clog2(MAX_X * MAX_Y);

	logic [SX_W-1:0]   size_x_q;
	logic [SY_W-1:0]   size_y_q;
	logic [SZ_W-1:0]   size_z_q;
	logic [MODE_W-1:0] mode_q;
	logic [XW-1:0]     sx_c;
	logic [YW-1:0]     sy_c;
	logic [ZW-1:0]     sz_c;
	logic [PLW-1:0]    plane_q;
	logic [QW-1:0]     delay_q;
	logic              flat_q;
	logic [1:0]        settle_q;
	logic              accept, push, full, pop, rd_valid;
	entry_t            wr_entry, rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SX_W'(128);
			size_y_q <= SY_W'(128);
			size_z_q <= SZ_W'(1);
			mode_q   <= MODE_FACE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SIZE_X: size_x_q <= cfg_wdata[SX_W-1:0];
				CFG_SIZE_Y: size_y_q <= cfg_wdata[SY_W-1:0];
				CFG_SIZE_Z: size_z_q <= cfg_wdata[SZ_W-1:0];
				CFG_NMODE:  mode_q   <= cfg_wdata[MODE_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (size_x_q == '0) sx_c = XW'(1);
		else if (32'(size_x_q) > MAX_X) sx_c = XW'(MAX_X);
		else sx_c = XW'(size_x_q);
		if (size_y_q == '0) sy_c = YW'(1);
		else if (32'(size_y_q) > MAX_Y) sy_c = YW'(MAX_Y);
		else sy_c = YW'(size_y_q);
		if (size_z_q == '0) sz_c = ZW'(1);
		else if (32'(size_z_q) > MAX_Z) sz_c = ZW'(MAX_Z);
		else sz_c = ZW'(size_z_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		plane_q <= PLW'(sx_c) * PLW'(sy_c);
		delay_q <= QW'(plane_q) + QW'(sx_c) + QW'(1);
		flat_q  <= (sz_c == ZW'(1));
	end

	assign in_ready = (settle_q == '0) && !full;
	assign accept   = in_valid && in_ready;

	mbvf_front #(.XW(XW), .YW(YW), .ZW(ZW), .QW(QW)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.sx(sx_c), .sy(sy_c), .sz(sz_c), .delay(delay_q),
		.accept(accept), .op(op), .mask_value(mask_value),
		.push(push), .entry(wr_entry)
	);

	mbvf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_entry(wr_entry), .full(full),
		.pop(pop), .rd_valid(rd_valid), .rd_entry(rd_entry)
	);

	mbvf_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.row_len(RPW'(sx_c - 1'b1)), .plane_len(PPW'(plane_q - 1'b1)),
		.flat(flat_q), .mode(mode_q),
		.rd_valid(rd_valid), .rd_entry(rd_entry), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.in_mask(in_mask), .is_boundary(is_boundary),
		.node_number(node_number), .last(last)
	);

endmodule

// ===== rtl/mbvf_front.sv =====
// Front end: accepts voxels, tracks input and output raster positions.
// Depends on mbvf_pkg.
module mbvf_front #(
	parameter int XW = 8,
	parameter int YW = 8,
	parameter int ZW = 11,
	parameter int QW = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [XW-1:0]     sx,
	input  logic [YW-1:0]     sy,
	input  logic [ZW-1:0]     sz,
	input  logic [QW-1:0]     delay,
	input  logic              accept,
	input  logic              op,
	input  logic signed [7:0] mask_value,
	output logic              push,
	output mbvf_pkg::entry_t  entry
);
	import mbvf_pkg::*;

	logic [QW-1:0] q_q;
	logic [XW-1:0] ix_q, ox_q;
	logic [YW-1:0] iy_q, oy_q;
	logic [ZW-1:0] iz_q, oz_q;
	logic          in_end_q;
	logic          drop;

	assign drop = (op == OP_PAD) && (q_q == '0);
	assign push = accept && !drop;

	always_comb begin
		entry.bit_in = !in_end_q && (op != OP_PAD) && !mask_value[7] && (mask_value[6:0] != '0);
		entry.emit   = (q_q >= delay);
		entry.xlo    = (ox_q == '0);
		entry.xhi    = (ox_q == sx - 1'b1);
		entry.ylo    = (oy_q == '0);
		entry.yhi    = (oy_q == sy - 1'b1);
		entry.zlo    = (oz_q == '0);
		entry.zhi    = (oz_q == sz - 1'b1);
		entry.last   = entry.xhi && entry.yhi && entry.zhi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q      <= '0;
			ix_q     <= '0;
			iy_q     <= '0;
			iz_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			oz_q     <= '0;
			in_end_q <= 1'b0;
		end else if (cfg_we) begin
			q_q      <= '0;
			ix_q     <= '0;
			iy_q     <= '0;
			iz_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			oz_q     <= '0;
			in_end_q <= 1'b0;
		end else if (push) begin
			q_q <= q_q + 1'b1;
			if (!in_end_q) begin
				if (ix_q == sx - 1'b1) begin
					ix_q <= '0;
					if (iy_q == sy - 1'b1) begin
						iy_q <= '0;
						if (iz_q == sz - 1'b1) begin
							iz_q     <= '0;
							in_end_q <= 1'b1;
						end else begin
							iz_q <= iz_q + 1'b1;
						end
					end else begin
						iy_q <= iy_q + 1'b1;
					end
				end else begin
					ix_q <= ix_q + 1'b1;
				end
			end
			if (entry.emit) begin
				if (entry.xhi) begin
					ox_q <= '0;
					if (entry.yhi) begin
						oy_q <= '0;
						oz_q <= entry.zhi ? '0 : oz_q + 1'b1;
					end else begin
						oy_q <= oy_q + 1'b1;
					end
				end else begin
					ox_q <= ox_q + 1'b1;
				end
				if (entry.last) begin
					q_q      <= '0;
					ix_q     <= '0;
					iy_q     <= '0;
					iz_q     <= '0;
					in_end_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/mbvf_queue.sv =====
// Two-entry queue between front end and window back end.
// Depends on mbvf_pkg.
module mbvf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mbvf_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output mbvf_pkg::entry_t rd_entry
);
	import mbvf_pkg::*;

	entry_t     slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_entry = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_entry;
	end

endmodule

// ===== rtl/mbvf_line.sv =====
// Programmable-length one-bit delay line on a circular memory.
// Output after an advance is the input of len advances earlier.
module mbvf_line #(
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     adv,
	input  logic [$clog2(DEPTH)-1:0] len,
	input  logic                     din,
	output logic                     dout
);
	localparam int PW = $clog2(DEPTH);

	logic          mem [DEPTH];
	logic [PW-1:0] ptr_q;
	logic          dout_q;

	assign dout = dout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (clr) begin
			ptr_q <= '0;
		end else if (adv && (len != '0)) begin
			ptr_q <= (ptr_q == len - 1'b1) ? '0 : ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dout_q     <= (len == '0) ? din : mem[ptr_q];
			mem[ptr_q] <= din;
		end
	end

endmodule

// ===== rtl/mbvf_back.sv =====
// Back end: 3x3x3 window from plane and row delay lines, boundary test,
// node counter and output register. Depends on mbvf_pkg, mbvf_line.
module mbvf_back #(
	parameter int MAX_X = 128,
	parameter int MAX_Y = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [$clog2(MAX_X)-1:0]         row_len,
	input  logic [$clog2(MAX_X*MAX_Y)-1:0]   plane_len,
	input  logic                             flat,
	input  logic [mbvf_pkg::MODE_W-1:0]      mode,
	input  logic                             rd_valid,
	input  mbvf_pkg::entry_t                 rd_entry,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             in_mask,
	output logic                             is_boundary,
	output logic [mbvf_pkg::NODE_W-1:0]      node_number,
	output logic                             last
);
	import mbvf_pkg::*;

	localparam int RDEPTH = MAX_X;
	localparam int PDEPTH = MAX_X * MAX_Y;

	logic              t0 [3][3];
	logic              d1_q [3][3];
	logic              d2_q [3][3];
	logic              center, bnd;
	logic              out_valid_q, in_mask_q, bnd_q, last_q;
	logic [NODE_W-1:0] node_q, cnt_q;

	assign t0[0][0] = rd_entry.bit_in;
	assign pop      = rd_valid && (!rd_entry.emit || !out_valid_q || out_ready);

	mbvf_line #(.DEPTH(PDEPTH)) u_plane1 (
		.clk(clk), .arst_n(arst_n), .clr(cfg_we), .adv(pop), .len(plane_len),
		.din(t0[0][0]), .dout(t0[1][0])
	);

	mbvf_line #(.DEPTH(PDEPTH)) u_plane2 (
		.clk(clk), .arst_n(arst_n), .clr(cfg_we), .adv(pop), .len(plane_len),
		.din(t0[1][0]), .dout(t0[2][0])
	);

	for (genvar a = 0; a < 3; a++) begin : g_rows
		mbvf_line #(.DEPTH(RDEPTH)) u_row1 (
			.clk(clk), .arst_n(arst_n), .clr(cfg_we), .adv(pop), .len(row_len),
			.din(t0[a][0]), .dout(t0[a][1])
		);
		mbvf_line #(.DEPTH(RDEPTH)) u_row2 (
			.clk(clk), .arst_n(arst_n), .clr(cfg_we), .adv(pop), .len(row_len),
			.din(t0[a][1]), .dout(t0[a][2])
		);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					d1_q[a][b] <= t0[a][b];
					d2_q[a][b] <= d1_q[a][b];
				end
			end
		end
	end

	assign center = d1_q[1][1];

	// a, b, e index dz, dy, dx reversed: index 0 is the +1 neighbour
	always_comb begin
		int   n;
		logic sel, oob, tap;
		bnd = 1'b0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				for (int e = 0; e < 3; e++) begin
					n = int'(a != 1) + int'(b != 1) + int'(e != 1);
					if (n == 0) sel = 1'b0;
					else if (flat) sel = (a == 1) && (n == 1);
					else if (mode == MODE_FACE) sel = (n == 1);
					else if (mode == MODE_EDGE) sel = (n <= 2);
					else sel = 1'b1;
					oob = (a == 0 && rd_entry.zhi) || (a == 2 && rd_entry.zlo) ||
					      (b == 0 && rd_entry.yhi) || (b == 2 && rd_entry.ylo) ||
					      (e == 0 && rd_entry.xhi) || (e == 2 && rd_entry.xlo);
					if (e == 0) tap = t0[a][b];
					else if (e == 1) tap = d1_q[a][b];
					else tap = d2_q[a][b];
					if (sel && (oob || !tap)) bnd = 1'b1;
				end
			end
		end
		bnd = bnd && center;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (pop && rd_entry.emit) begin
				out_valid_q <= 1'b1;
				if (rd_entry.last) cnt_q <= '0;
				else if (center) cnt_q <= cnt_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && rd_entry.emit) begin
			in_mask_q <= center;
			bnd_q     <= bnd;
			node_q    <= cnt_q;
			last_q    <= rd_entry.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign in_mask     = in_mask_q;
	assign is_boundary = bnd_q;
	assign node_number = node_q;
	assign last        = last_q;

endmodule

// ===== rtl/mbvf_checker.sv =====
// Port-level checks for the mask boundary voxel finder, with bind.
// Depends on mbvf_pkg and mask_boundary_voxel_finder_unit.
module mbvf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        in_mask,
	input logic                        is_boundary,
	input logic [mbvf_pkg::NODE_W-1:0] node_number,
	input logic                        last
);
	import mbvf_pkg::*;

	logic [NODE_W-1:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (cfg_we) begin
			exp_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_q <= last ? '0 : node_number + NODE_W'(in_mask);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({in_mask, is_boundary, node_number, last}))
		else $error("result transaction changed while stalled");

	a_bnd_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !is_boundary || in_mask)
		else $error("boundary flagged outside mask");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input taken while sizes settle");

	a_node_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> node_number == exp_q)
		else $error("node number out of sequence");

endmodule

bind mask_boundary_voxel_finder_unit mbvf_checker u_mbvf_checker (.*);

// ===== test/tb_mask_boundary_voxel_finder_unit.sv =====
// Self-checking bench for mask_boundary_voxel_finder_unit: volumes of mask voxels and pads
// are streamed under random idling, each result is checked against a local window predictor.
// Depends on mbvf_pkg and the block RTL only.
module tb_mask_boundary_voxel_finder_unit;
	import mbvf_pkg::*;

	localparam int WIN = 2*DEF_MAX_X*DEF_MAX_Y + 2*DEF_MAX_X + 3;

	typedef struct packed {
		logic             in_mask;
		logic             is_boundary;
		logic [NODE_W-1:0] node_number;
		logic             last;
	} voxel_res_t;

	typedef struct {
		logic        op;
		logic [7:0]  val;
		logic        has_res;
		voxel_res_t  res;
	} dir_row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid, in_ready, op;
	logic signed [7:0] mask_value;
	logic out_valid, out_ready, in_mask, is_boundary, last;
	logic [NODE_W-1:0] node_number;

	mask_boundary_voxel_finder_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready), .op(op),
		.mask_value(mask_value), .out_valid(out_valid), .out_ready(out_ready),
		.in_mask(in_mask), .is_boundary(is_boundary), .node_number(node_number),
		.last(last)
	);

	// predictor state
	bit win_bits [WIN];
	longint unsigned in_pos, out_pos, mask_cnt;
	logic [7:0] reg_sx, reg_sy;
	logic [10:0] reg_sz;
	logic [1:0] reg_mode;

	voxel_res_t expected_q[$];
	int errors, mismatches;
	bit quiet;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned clampv(longint unsigned v, longint unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic bit nb_used(int dx, int dy, int dz, bit flat, logic [1:0] m);
		int n;
		n = (dx != 0) + (dy != 0) + (dz != 0);
		if (n == 0) return 0;
		if (flat) return dz == 0 && n == 1;
		if (m == MODE_FACE) return n == 1;
		if (m == MODE_EDGE) return n <= 2;
		return 1;
	endfunction

	task automatic write_reg(cfg_reg_t idx, int val);
		in_valid <= 0;
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_SIZE_X: reg_sx = val[7:0];
			CFG_SIZE_Y: reg_sy = val[7:0];
			CFG_SIZE_Z: reg_sz = val[10:0];
			default:    reg_mode = val[1:0];
		endcase
		in_pos = 0; out_pos = 0; mask_cnt = 0;
		@(posedge clk);
	endtask

	// returns 1 and a result when the voxel window completes one
	function automatic bit predict_boundary(logic o, logic [7:0] v, output voxel_res_t r);
		longint unsigned sx, sy, sz, pl, total, dly, q, p;
		longint x, y, z, nx, ny, nz;
		bit b, c, bnd, flat;
		sx = clampv(reg_sx, DEF_MAX_X);
		sy = clampv(reg_sy, DEF_MAX_Y);
		sz = clampv(reg_sz, DEF_MAX_Z);
		pl = sx*sy; total = pl*sz; dly = pl + sx + 1;
		q = in_pos; bnd = 0; flat = (sz == 1);
		r = '0;
		if (o == OP_PAD && q == 0) return 0;
		b = (q < total) && o != OP_PAD && !v[7] && v[6:0] != 0;
		win_bits[q % WIN] = b;
		in_pos = q + 1;
		if (q < dly) return 0;
		p = out_pos;
		x = p % sx; y = (p / sx) % sy; z = p / pl;
		c = win_bits[p % WIN];
		if (c)
			for (int dz = -1; dz <= 1; dz++)
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++) begin
						if (!nb_used(dx, dy, dz, flat, reg_mode)) continue;
						nx = x+dx; ny = y+dy; nz = z+dz;
						if (nx < 0 || ny < 0 || nz < 0 || nx >= sx || ny >= sy || nz >= sz)
							bnd = 1;
						else if (!win_bits[(nx + ny*sx + nz*pl) % WIN])
							bnd = 1;
					end
		r.in_mask = c;
		r.is_boundary = bnd;
		r.node_number = mask_cnt[NODE_W-1:0];
		r.last = (p + 1 == total);
		if (c) mask_cnt++;
		out_pos = p + 1;
		if (p + 1 == total) begin
			in_pos = 0; out_pos = 0; mask_cnt = 0;
		end
		return 1;
	endfunction

	task automatic send_voxel(logic o, logic [7:0] v, bit chk, voxel_res_t want);
		voxel_res_t r;
		while (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; op <= o; mask_value <= v;
		do @(posedge clk); while (!in_ready);
		if (predict_boundary(o, v, r)) begin
			if (chk && r != want) begin
				errors++;
				$display("directed row disagrees with predictor: %h vs %h", want, r);
			end
			expected_q.insert(expected_q.size(), r);
		end
	endtask

	// result side
	always @(posedge clk) begin
		voxel_res_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{in_mask, is_boundary, node_number, last};
			if (expected_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got != want) begin
					errors++;
					if (mismatches++ < 10)
						$display("result mismatch: expected %h got %h", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) out_ready <= 0;
		else out_ready <= quiet || ($urandom_range(99) >= 6);
	end

	task automatic drain();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one volume, padded until every result has come out
	task automatic run_volume(int sx, int sy, int sz, int md, int dense);
		longint unsigned nv;
		nv = clampv(sx, DEF_MAX_X) * clampv(sy, DEF_MAX_Y) * clampv(sz, DEF_MAX_Z);
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
		write_reg(CFG_NMODE, md);
		for (longint unsigned i = 0; i < nv; i++) begin
			if ($urandom_range(99) < 3)
				send_voxel(OP_PAD, 8'($urandom), 0, '0);
			else if ($urandom_range(99) < dense)
				send_voxel(OP_VOXEL, 8'($urandom_range(1, 127)), 0, '0);
			else
				send_voxel(OP_VOXEL, 8'($urandom), 0, '0);
		end
		while (in_pos != 0) send_voxel(1'($urandom_range(1)), 8'($urandom), 0, '0);
		drain();
	endtask

	dir_row_t dir_tab[$];

	initial begin
		dir_row_t row;
		errors = 0; mismatches = 0; quiet = 0;
		arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
		in_valid = 0; op = 0; mask_value = 0;
		reg_sx = 128; reg_sy = 128; reg_sz = 1; reg_mode = 0;
		in_pos = 0; out_pos = 0; mask_cnt = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// pad with nothing pending after reset is dropped
		send_voxel(OP_PAD, 8'h00, 0, '0);
		// directed: 3x3x1, centre only inner voxel, extremes of value
		write_reg(CFG_SIZE_X, 3);
		write_reg(CFG_SIZE_Y, 3);
		write_reg(CFG_SIZE_Z, 1);
		write_reg(CFG_NMODE, MODE_FACE);
		dir_tab = '{
			'{OP_VOXEL, 8'h7f, 0, '0}, '{OP_VOXEL, 8'h01, 0, '0}, '{OP_VOXEL, 8'h80, 0, '0},
			'{OP_VOXEL, 8'hff, 0, '0}, '{OP_VOXEL, 8'h00, 0, '0}, '{OP_PAD, 8'h55, 0, '0},
			'{OP_VOXEL, 8'h40, 0, '0}, '{OP_VOXEL, 8'h7f, 0, '0}, '{OP_VOXEL, 8'h01, 0, '0},
			'{OP_PAD, 8'h00, 0, '0}, '{OP_PAD, 8'h00, 0, '0}, '{OP_PAD, 8'h00, 0, '0},
			'{OP_VOXEL, 8'h12, 0, '0}, '{OP_PAD, 8'h00, 0, '0}, '{OP_PAD, 8'h00, 0, '0},
			'{OP_PAD, 8'h00, 0, '0}, '{OP_PAD, 8'h00, 0, '0}, '{OP_PAD, 8'h00, 0, '0},
			'{OP_PAD, 8'h00, 0, '0}, '{OP_PAD, 8'h00, 0, '0}, '{OP_PAD, 8'h00, 0, '0},
			'{OP_PAD, 8'h00, 1, '{1'b1, 1'b1, 24'd4, 1'b1}}
		};
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			send_voxel(row.op, row.val, row.has_res, row.res);
		end
		drain();
		// sizes clamped, unused mode, 1x1x1 and 0 sizes
		run_volume(0, 0, 0, 3, 90);
		run_volume(1, 1, 5, 2, 90);
		run_volume(255, 1, 1, 1, 90);
		run_volume(3, 3, 3, 0, 95);
		run_volume(4, 3, 3, 1, 90);
		run_volume(3, 4, 3, 2, 90);
		run_volume(1, 6, 2, 3, 60);
		run_volume(5, 4, 4, 1, 85);
		quiet = 1;
		run_volume(6, 5, 3, 2, 90);
		quiet = 0;
		run_volume(2, 3, 24, 0, 80);
		run_volume(7, 2, 10, 1, 50);
		drain();
		if (errors == 0)
			$display("tb_mask_boundary_voxel_finder_unit OK");
		else
			$display("tb_mask_boundary_voxel_finder_unit NOT OK");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_mask_boundary_voxel_finder_unit NOT OK");
		$finish;
	end
endmodule
